[src/triangle_box_overlap_macros.svh]
// assertion macros for the triangle/box overlap checker
// used by tba_checker only
`ifndef TRIANGLE_BOX_OVERLAP_MACROS_SVH
`define TRIANGLE_BOX_OVERLAP_MACROS_SVH

// implication checked outside reset
`define TBA_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on every edge
`define TBA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

[src/tba_pkg.sv]
// shared constants for the triangle/box overlap block
// no dependencies
`default_nettype none

package tba_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int VERTEX_BITS    = 48;
  localparam int MODE_BITS      = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_VERTEX_ZERO    = 2'd0,
    REG_VERTEX_ONE     = 2'd1,
    REG_VERTEX_TWO     = 2'd2,
    REG_DIMENSION_MODE = 2'd3
  } cfg_index_t;

  localparam logic [MODE_BITS-1:0] MODE_2D    = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_RESET = 2'd3;

endpackage

`default_nettype wire

[src/tba_edge_axis.sv]
// one edge-cross-axis separation test, two register stages
// products, then projection interval compare; no package use
`default_nettype none

module tba_edge_axis #(
  parameter int CB = 16
) (
  input  wire logic                 clk,
  input  wire logic signed [CB:0]   ea,
  input  wire logic signed [CB:0]   eb,
  input  wire logic signed [CB+1:0] vpa,
  input  wire logic signed [CB+1:0] vpb,
  input  wire logic signed [CB+1:0] vqa,
  input  wire logic signed [CB+1:0] vqb,
  input  wire logic signed [CB:0]   ha,
  input  wire logic signed [CB:0]   hb,
  output logic                      sep
);

  localparam int AW = CB + 2;
  localparam int PW = 2 * CB + 3;
  localparam int W  = 2 * CB + 5;

  logic signed [AW-1:0] ea_w, eb_w, ea_abs, eb_abs;
  logic signed [PW-1:0] pa, pb, qa, qb, ra, rb;
  logic signed [W-1:0]  p, q, rad, lo, hi;

  always_comb begin
    ea_w   = AW'(ea);
    eb_w   = AW'(eb);
    ea_abs = (ea_w < 0) ? -ea_w : ea_w;
    eb_abs = (eb_w < 0) ? -eb_w : eb_w;
  end

  always_ff @(posedge clk) begin
    pa <= PW'(ea) * PW'(vpa);
    pb <= PW'(eb) * PW'(vpb);
    qa <= PW'(ea) * PW'(vqa);
    qb <= PW'(eb) * PW'(vqb);
    ra <= PW'(ea_abs) * PW'(ha);
    rb <= PW'(eb_abs) * PW'(hb);
  end

  always_comb begin
    p   = W'(pa) - W'(pb);
    q   = W'(qa) - W'(qb);
    rad = W'(ra) + W'(rb);
    lo  = (p < q) ? p : q;
    hi  = (p < q) ? q : p;
  end

  always_ff @(posedge clk) begin
    sep <= (lo > rad) || (hi < -rad);
  end

endmodule

`default_nettype wire

[src/tba_normal.sv]
// triangle normal axis test, three register stages plus final sum
// edge products, normal and box bounds, wide products; no package use
`default_nettype none

module tba_normal #(
  parameter int CB = 16
) (
  input  wire logic                 clk,
  input  wire logic signed [CB:0]   e0 [3],
  input  wire logic signed [CB:0]   e1 [3],
  input  wire logic signed [CB+1:0] v0 [3],
  input  wire logic signed [CB:0]   h  [3],
  output logic                      sep
);

  localparam int NW = 2 * CB + 3;
  localparam int LW = CB + 3;
  localparam int MW = 3 * CB + 6;
  localparam int SW = 3 * CB + 8;

  logic signed [NW-1:0]   pr [6];
  logic signed [CB+1:0]   v0_c [3];
  logic signed [CB:0]     h_c  [3];
  logic signed [NW-1:0]   n    [3];
  logic signed [LW-1:0]   lo   [3];
  logic signed [LW-1:0]   hi   [3];
  logic signed [MW-1:0]   pmin [3];
  logic signed [MW-1:0]   pmax [3];
  logic signed [SW-1:0]   smin, smax;

  always_ff @(posedge clk) begin
    pr[0] <= NW'(e0[1]) * NW'(e1[2]);
    pr[1] <= NW'(e0[2]) * NW'(e1[1]);
    pr[2] <= NW'(e0[2]) * NW'(e1[0]);
    pr[3] <= NW'(e0[0]) * NW'(e1[2]);
    pr[4] <= NW'(e0[0]) * NW'(e1[1]);
    pr[5] <= NW'(e0[1]) * NW'(e1[0]);
    for (int i = 0; i < 3; i++) begin
      v0_c[i] <= v0[i];
      h_c[i]  <= h[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n[i]  <= pr[2*i] - pr[2*i+1];
      lo[i] <= -LW'(h_c[i]) - LW'(v0_c[i]);
      hi[i] <= LW'(h_c[i]) - LW'(v0_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (n[i] > 0) begin
        pmin[i] <= MW'(n[i]) * MW'(lo[i]);
        pmax[i] <= MW'(n[i]) * MW'(hi[i]);
      end else begin
        pmin[i] <= MW'(n[i]) * MW'(hi[i]);
        pmax[i] <= MW'(n[i]) * MW'(lo[i]);
      end
    end
  end

  always_comb begin
    smin = SW'(pmin[0]) + SW'(pmin[1]) + SW'(pmin[2]);
    smax = SW'(pmax[0]) + SW'(pmax[1]) + SW'(pmax[2]);
    sep  = (smin > 0) || (smax < 0);
  end

endmodule

`default_nettype wire

[src/triangle_box_overlap.sv]
// triangle versus axis-aligned cell overlap, separating axis test
// result strobe done follows acceptance via valid chain va, vb, vc, vd, ve
// one cell per clock while busy is low; busy is registered and set in rst
// rst clears the vertices to 0, mode to 3d and flushes the pipeline
// depends on tba_pkg, tba_edge_axis, tba_normal
`default_nettype none

module triangle_box_overlap #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_BITS-1:0]  cell_min_x,
  input  wire logic signed [COORD_BITS-1:0]  cell_min_y,
  input  wire logic signed [COORD_BITS-1:0]  cell_min_z,
  input  wire logic signed [COORD_BITS-1:0]  cell_max_x,
  input  wire logic signed [COORD_BITS-1:0]  cell_max_y,
  input  wire logic signed [COORD_BITS-1:0]  cell_max_z,
  output logic                               done,
  output logic                               overlaps,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tba_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tba_pkg::VERTEX_BITS-1:0]    cfg_data
);

  import tba_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int VW = (3 * CB > VERTEX_BITS) ? 3 * CB : VERTEX_BITS;

  logic [VERTEX_BITS-1:0] vtx [3];
  logic [MODE_BITS-1:0]   mode;
  logic [VW-1:0]          vtx_w [3];

  logic signed [CB-1:0]   xa [3][3];
  logic signed [CB-1:0]   mn_a [3];
  logic signed [CB-1:0]   mx_a [3];
  logic                   d3_a, d3_b, d3_c, d3_d, d3_e;
  logic                   va, vb, vc, vd, ve;

  logic signed [CB:0]     e_b [3][3];
  logic signed [CB+1:0]   v_b [3][3];
  logic signed [CB:0]     h_b [3];

  logic signed [CB:0]     c2 [3];
  logic signed [CB+2:0]   vmin, vmax, hw;
  logic                   bsep_next;
  logic                   bsep_c, bsep_d, bsep_e;
  logic                   sep [9];
  logic                   zsep_e, xysep_e;
  logic                   nsep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx[0] <= '0;
      vtx[1] <= '0;
      vtx[2] <= '0;
      mode   <= MODE_RESET;
      busy   <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_t'(cfg_index))
          REG_VERTEX_ZERO:    vtx[0] <= cfg_data;
          REG_VERTEX_ONE:     vtx[1] <= cfg_data;
          REG_VERTEX_TWO:     vtx[2] <= cfg_data;
          REG_DIMENSION_MODE: mode   <= cfg_data[MODE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vtx_w[k] = VW'(vtx[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; ve <= 1'b0; done <= 1'b0;
    end else begin
      va   <= start && !busy;
      vb   <= va;
      vc   <= vb;
      vd   <= vc;
      ve   <= vd;
      done <= ve;
    end
  end

  // stage a: capture
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        xa[k][i] <= $signed(vtx_w[k][i*CB +: CB]);
      end
    end
    mn_a[0] <= cell_min_x; mn_a[1] <= cell_min_y; mn_a[2] <= cell_min_z;
    mx_a[0] <= cell_max_x; mx_a[1] <= cell_max_y; mx_a[2] <= cell_max_z;
    d3_a    <= (mode != MODE_2D);
  end

  // stage b: edges, doubled centered vertices, doubled half sizes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c2[i] = (CB+1)'(mn_a[i]) + (CB+1)'(mx_a[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e_b[0][i] <= (CB+1)'(xa[1][i]) - (CB+1)'(xa[0][i]);
      e_b[1][i] <= (CB+1)'(xa[2][i]) - (CB+1)'(xa[1][i]);
      e_b[2][i] <= (CB+1)'(xa[2][i]) - (CB+1)'(xa[0][i]);
      h_b[i]    <= (CB+1)'(mx_a[i]) - (CB+1)'(mn_a[i]);
      for (int k = 0; k < 3; k++) begin
        v_b[k][i] <= (CB+2)'(xa[k][i]) + (CB+2)'(xa[k][i]) - (CB+2)'(c2[i]);
      end
    end
    d3_b <= d3_a;
  end

  // stage c: bounding ranges
  always_comb begin
    bsep_next = 1'b0;
    vmin = '0;
    vmax = '0;
    hw   = '0;
    for (int i = 0; i < 3; i++) begin
      vmin = (CB+3)'(v_b[0][i]);
      vmax = (CB+3)'(v_b[0][i]);
      hw   = (CB+3)'(h_b[i]);
      for (int k = 1; k < 3; k++) begin
        if ((CB+3)'(v_b[k][i]) < vmin) vmin = (CB+3)'(v_b[k][i]);
        if ((CB+3)'(v_b[k][i]) > vmax) vmax = (CB+3)'(v_b[k][i]);
      end
      if ((i < 2 || d3_b) && (vmin > hw || vmax < -hw)) bsep_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bsep_c <= bsep_next;
    d3_c   <= d3_b;
    bsep_d <= bsep_c;
    d3_d   <= d3_c;
    bsep_e <= bsep_d;
    d3_e   <= d3_d;
    zsep_e  <= sep[0] || sep[1] || sep[2];
    xysep_e <= sep[3] || sep[4] || sep[5] || sep[6] || sep[7] || sep[8];
  end

  tba_edge_axis #(.CB(CB)) u_z0 (.clk(clk), .ea(e_b[0][1]), .eb(e_b[0][0]),
    .vpa(v_b[1][0]), .vpb(v_b[1][1]), .vqa(v_b[2][0]), .vqb(v_b[2][1]),
    .ha(h_b[0]), .hb(h_b[1]), .sep(sep[0]));
  tba_edge_axis #(.CB(CB)) u_z1 (.clk(clk), .ea(e_b[1][1]), .eb(e_b[1][0]),
    .vpa(v_b[0][0]), .vpb(v_b[0][1]), .vqa(v_b[1][0]), .vqb(v_b[1][1]),
    .ha(h_b[0]), .hb(h_b[1]), .sep(sep[1]));
  tba_edge_axis #(.CB(CB)) u_z2 (.clk(clk), .ea(e_b[2][1]), .eb(e_b[2][0]),
    .vpa(v_b[1][0]), .vpb(v_b[1][1]), .vqa(v_b[2][0]), .vqb(v_b[2][1]),
    .ha(h_b[0]), .hb(h_b[1]), .sep(sep[2]));
  tba_edge_axis #(.CB(CB)) u_x0 (.clk(clk), .ea(e_b[0][2]), .eb(e_b[0][1]),
    .vpa(v_b[0][1]), .vpb(v_b[0][2]), .vqa(v_b[2][1]), .vqb(v_b[2][2]),
    .ha(h_b[1]), .hb(h_b[2]), .sep(sep[3]));
  tba_edge_axis #(.CB(CB)) u_y0 (.clk(clk), .ea(e_b[0][0]), .eb(e_b[0][2]),
    .vpa(v_b[0][2]), .vpb(v_b[0][0]), .vqa(v_b[2][2]), .vqb(v_b[2][0]),
    .ha(h_b[2]), .hb(h_b[0]), .sep(sep[4]));
  tba_edge_axis #(.CB(CB)) u_x1 (.clk(clk), .ea(e_b[1][2]), .eb(e_b[1][1]),
    .vpa(v_b[0][1]), .vpb(v_b[0][2]), .vqa(v_b[2][1]), .vqb(v_b[2][2]),
    .ha(h_b[1]), .hb(h_b[2]), .sep(sep[5]));
  tba_edge_axis #(.CB(CB)) u_y1 (.clk(clk), .ea(e_b[1][0]), .eb(e_b[1][2]),
    .vpa(v_b[0][2]), .vpb(v_b[0][0]), .vqa(v_b[2][2]), .vqb(v_b[2][0]),
    .ha(h_b[2]), .hb(h_b[0]), .sep(sep[6]));
  tba_edge_axis #(.CB(CB)) u_x2 (.clk(clk), .ea(e_b[2][2]), .eb(e_b[2][1]),
    .vpa(v_b[0][1]), .vpb(v_b[0][2]), .vqa(v_b[1][1]), .vqb(v_b[1][2]),
    .ha(h_b[1]), .hb(h_b[2]), .sep(sep[7]));
  tba_edge_axis #(.CB(CB)) u_y2 (.clk(clk), .ea(e_b[2][0]), .eb(e_b[2][2]),
    .vpa(v_b[0][2]), .vpb(v_b[0][0]), .vqa(v_b[1][2]), .vqb(v_b[1][0]),
    .ha(h_b[2]), .hb(h_b[0]), .sep(sep[8]));

  tba_normal #(.CB(CB)) u_normal (
    .clk (clk),
    .e0  (e_b[0]),
    .e1  (e_b[1]),
    .v0  (v_b[0]),
    .h   (h_b),
    .sep (nsep)
  );

  always_ff @(posedge clk) begin
    overlaps <= !(bsep_e || zsep_e || (d3_e && (xysep_e || nsep)));
  end

endmodule

`default_nettype wire

[src/tba_checker.sv]
// port-level checker for triangle_box_overlap, bound to the top level
// depends on triangle_box_overlap_macros.svh
`default_nettype none

`include "triangle_box_overlap_macros.svh"

module tba_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  `TBA_ASSERT_RST(a_req_gives_done, start && !busy, ##6 done, "request without result")
  `TBA_ASSERT_RST(a_done_has_req, done, $past(start && !busy, 6), "result without request")
  `TBA_ASSERT_RST(a_reset_flush, $past(rst), !done, "result right after reset")
  `TBA_ASSERT(a_reset_busy, rst, ##1 busy, "busy low after reset")

endmodule

bind triangle_box_overlap tba_checker u_tba_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire

[bench/tb_top.sv]
// testbench for triangle_box_overlap: directed and random cells checked against
// a behavioral separating-axis predictor; depends on tba_pkg and the block rtl
`timescale 1ns / 1ps

module tb_top;
  import tba_pkg::*;

  localparam int CB = 16;
  localparam int LATENCY = 6;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic signed [CB-1:0] mnx, mny, mnz, mxx, mxy, mxz;
  } cell_t;

  logic clk = 0, rst = 1, start = 0, cfg_valid = 0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [VERTEX_BITS-1:0] cfg_data = '0;
  logic signed [CB-1:0] cell_min_x = 0, cell_min_y = 0, cell_min_z = 0;
  logic signed [CB-1:0] cell_max_x = 0, cell_max_y = 0, cell_max_z = 0;
  logic busy, done, overlaps, cfg_ready;

  logic [VERTEX_BITS-1:0] vtx [3];
  logic [MODE_BITS-1:0] mode;
  bit expected_flags [$];
  int mismatches = 0, unexpected = 0, checked = 0, sent = 0;
  longint cycles = 0;

  triangle_box_overlap dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_flags.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10) $display("unexpected result %0b", overlaps);
      end else begin
        bit e;
        e = expected_flags.pop_front();
        checked++;
        if (overlaps !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("overlaps mismatch: expected %0b got %0b", e, overlaps);
        end
      end
    end
  end

  function automatic longint sx(logic [CB-1:0] r);
    return longint'($signed(r));
  endfunction

  function automatic bit apart(longint p, longint q, longint rad);
    longint lo, hi;
    lo = p < q ? p : q;
    hi = p < q ? q : p;
    return lo > rad || hi < -rad;
  endfunction

  function automatic longint mag(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic bit edge_sep(longint ea, longint eb, int ia, int ib,
                                  longint vp[3], longint vq[3], longint h[3]);
    return apart(ea*vp[ia] - eb*vp[ib], ea*vq[ia] - eb*vq[ib],
                 mag(ea)*h[ia] + mag(eb)*h[ib]);
  endfunction

  function automatic bit predict_overlap(cell_t c);
    longint x[3][3], v[3][3], h[3], e0[3], e1[3], e2[3], n[3];
    longint a[3], b[3], vmin, vmax;
    logic signed [127:0] pmin, pmax, lo, hi;
    int dims;
    dims = (mode == MODE_2D) ? 2 : 3;
    a = '{sx(c.mnx), sx(c.mny), sx(c.mnz)};
    b = '{sx(c.mxx), sx(c.mxy), sx(c.mxz)};
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) x[k][i] = sx(vtx[k][i*CB +: CB]);
    for (int i = 0; i < 3; i++) begin
      e0[i] = x[1][i] - x[0][i];
      e1[i] = x[2][i] - x[1][i];
      e2[i] = x[2][i] - x[0][i];
    end
    for (int i = 0; i < 3; i++) begin
      h[i] = b[i] - a[i];
      for (int k = 0; k < 3; k++) v[k][i] = 2*x[k][i] - (a[i] + b[i]);
      if (i < dims) begin
        vmin = v[0][i]; vmax = v[0][i];
        for (int k = 1; k < 3; k++) begin
          if (v[k][i] < vmin) vmin = v[k][i];
          if (v[k][i] > vmax) vmax = v[k][i];
        end
        if (vmin > h[i] || vmax < -h[i]) return 0;
      end
    end
    if (edge_sep(e0[1], e0[0], 0, 1, v[1], v[2], h)) return 0;
    if (edge_sep(e1[1], e1[0], 0, 1, v[0], v[1], h)) return 0;
    if (edge_sep(e2[1], e2[0], 0, 1, v[1], v[2], h)) return 0;
    if (dims == 2) return 1;
    if (edge_sep(e0[2], e0[1], 1, 2, v[0], v[2], h)) return 0;
    if (edge_sep(e0[0], e0[2], 2, 0, v[0], v[2], h)) return 0;
    if (edge_sep(e1[2], e1[1], 1, 2, v[0], v[2], h)) return 0;
    if (edge_sep(e1[0], e1[2], 2, 0, v[0], v[2], h)) return 0;
    if (edge_sep(e2[2], e2[1], 1, 2, v[0], v[1], h)) return 0;
    if (edge_sep(e2[0], e2[2], 2, 0, v[0], v[1], h)) return 0;
    n[0] = e0[1]*e1[2] - e0[2]*e1[1];
    n[1] = e0[2]*e1[0] - e0[0]*e1[2];
    n[2] = e0[0]*e1[1] - e0[1]*e1[0];
    pmin = 0; pmax = 0;
    for (int i = 0; i < 3; i++) begin
      lo = -h[i] - v[0][i];
      hi = h[i] - v[0][i];
      if (n[i] > 0) begin
        pmin += 128'(signed'(n[i])) * lo;
        pmax += 128'(signed'(n[i])) * hi;
      end else begin
        pmin += 128'(signed'(n[i])) * hi;
        pmax += 128'(signed'(n[i])) * lo;
      end
    end
    if (pmin > 0 || pmax < 0) return 0;
    return 1;
  endfunction

  task automatic idle_gap();
    int r, len;
    r = $urandom_range(0, 99);
    len = r < 55 ? 0 : r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (len > 0) start <= 0;
    repeat (len) @(negedge clk);
  endtask

  task automatic send_cell(cell_t c, bit gaps = 1);
    if (gaps) idle_gap();
    start <= 1;
    {cell_min_x, cell_min_y, cell_min_z, cell_max_x, cell_max_y, cell_max_z} <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_flags.push_back(predict_overlap(c));
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 0;
    while (expected_flags.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [VERTEX_BITS-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_DIMENSION_MODE) mode = val[MODE_BITS-1:0];
    else vtx[idx] = val;
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [VERTEX_BITS-1:0] pack_vertex(int px, int py, int pz);
    return {16'(pz), 16'(py), 16'(px)};
  endfunction

  function automatic cell_t random_cell(int span, bit sorted);
    cell_t c;
    int lo[3], w[3];
    for (int i = 0; i < 3; i++) begin
      lo[i] = $urandom_range(0, 2*span) - span;
      w[i] = $urandom_range(0, span);
    end
    c.mnx = CB'(lo[0]); c.mny = CB'(lo[1]); c.mnz = CB'(lo[2]);
    c.mxx = CB'(lo[0] + w[0]); c.mxy = CB'(lo[1] + w[1]); c.mxz = CB'(lo[2] + w[2]);
    if (!sorted) c = {c.mxx, c.mny, c.mxz, c.mnx, c.mxy, c.mnz};
    return c;
  endfunction

  task automatic set_triangle(int span);
    for (int k = 0; k < 3; k++)
      write_reg(cfg_index_t'(k), {16'($urandom), 16'($urandom_range(0, 2*span) - span),
                 16'($urandom_range(0, 2*span) - span)} & 48'hffff_0000_0000 |
                 pack_vertex($urandom_range(0, 2*span) - span,
                             $urandom_range(0, 2*span) - span,
                             $urandom_range(0, 2*span) - span));
  endtask

  task automatic test_directed();
    write_reg(REG_VERTEX_ZERO, pack_vertex(0, 0, 0));
    write_reg(REG_VERTEX_ONE, pack_vertex(100, 0, 0));
    write_reg(REG_VERTEX_TWO, pack_vertex(0, 100, 50));
    write_reg(REG_DIMENSION_MODE, 3);
    send_cell('{10, 10, 0, 20, 20, 30});
    send_cell('{200, 200, 200, 300, 300, 300});
    send_cell('{60, 60, -10, 90, 90, 10});
    send_cell('{20, 20, 20, 10, 10, 10});              // inverted cell
    send_cell('{-32768, -32768, -32768, 32767, 32767, 32767});
    send_cell('{32767, 32767, 32767, -32768, -32768, -32768});
    send_cell('{0, 0, 40, 10, 10, 45});
    wait_drained();
    write_reg(REG_DIMENSION_MODE, MODE_2D);
    send_cell('{0, 0, 40, 10, 10, 45});
    send_cell('{60, 60, 0, 90, 90, 0});
    wait_drained();
    for (int m = 0; m < 2; m++) begin
      write_reg(REG_DIMENSION_MODE, m);
      send_cell('{0, 0, 40, 10, 10, 45});
      wait_drained();
    end
    // degenerate triangle: collinear vertices
    write_reg(REG_VERTEX_ONE, pack_vertex(50, 50, 50));
    write_reg(REG_VERTEX_TWO, pack_vertex(100, 100, 100));
    write_reg(REG_DIMENSION_MODE, 3);
    send_cell('{40, 40, 40, 60, 60, 60});
    send_cell('{40, 60, 40, 45, 70, 45});
    wait_drained();
    // extreme vertices stress the wide normal sums
    write_reg(REG_VERTEX_ZERO, pack_vertex(-32768, -32768, 32767));
    write_reg(REG_VERTEX_ONE, pack_vertex(32767, -32768, -32768));
    write_reg(REG_VERTEX_TWO, {48{1'b1}} ^ pack_vertex(32767, 0, 32767));
    send_cell('{-32768, -32768, -32768, 32767, 32767, 32767});
    send_cell('{0, 0, 0, 1, 1, 1});
    send_cell('{-1000, 5000, -20000, 3000, 9000, 100});
    wait_drained();
  endtask

  task automatic test_random(int count, int span, logic [1:0] m);
    set_triangle(span);
    write_reg(REG_DIMENSION_MODE, m);
    for (int j = 0; j < count; j++) begin
      if (j % 40 == 39) begin
        wait_drained();
        set_triangle(span);
      end
      send_cell(random_cell(span, $urandom_range(0, 9) != 0), j % 100 >= 30);
    end
    wait_drained();
  endtask

  task automatic test_raw_noise(int count);
    for (int j = 0; j < count; j++) send_cell(cell_t'({$urandom, $urandom, $urandom}));
    wait_drained();
  endtask

  initial begin
    mode = MODE_RESET;
    for (int k = 0; k < 3; k++) vtx[k] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_random(300, 200, 3);
    test_random(250, 200, MODE_2D);
    test_random(200, 30000, 3);
    test_random(150, 30000, MODE_2D);
    test_random(100, 2000, 0);
    test_random(50, 2000, 1);
    test_raw_noise(80);
    $display("sent %0d cells over 2d, 3d and odd modes; %0d results checked",
             sent, checked);
    if (mismatches == 0 && unexpected == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d unexpected results", mismatches, unexpected);
      $display("FAIL");
    end
    $finish;
  end
endmodule
